/* sv/stepper_trapezoid_ramp_core_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the ramp core
// ---------------------------------------------------------------------------
`ifndef STEPPER_TRAPEZOID_RAMP_CORE_MACROS_SVH
`define STEPPER_TRAPEZOID_RAMP_CORE_MACROS_SVH

// check an implication on every clock edge outside reset
`define STR_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// check an implication in the next cycle
`define STR_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

/* sv/str_pkg.sv */
// ---------------------------------------------------------------------------
// Stepper ramp package
// Shared widths, codes and the request type for the ramp core.
// ---------------------------------------------------------------------------
`default_nettype none
package str_pkg;
    localparam int RampDepth  = 4096;
    localparam int RampAw     = $clog2(RampDepth);
    localparam int MinSpeed   = 10;
    localparam int DelayW     = 27;
    localparam int SpeedW     = 28;
    localparam int StepW      = 16;
    localparam int TopW       = 12;
    localparam int QueueDepth = 2;

    localparam logic [1:0] PH_ACCEL  = 2'd0;
    localparam logic [1:0] PH_CRUISE = 2'd1;
    localparam logic [1:0] PH_DECEL  = 2'd2;

    localparam logic [DelayW-1:0] DELAY_MAX = {DelayW{1'b1}};
    localparam logic [DelayW-1:0] DELAY_RST = DelayW'(100000000);
    // 1e9 * 65536
    localparam logic [45:0] NS_Q16 = 46'd65536000000000;
    // 1e9 = 512 * 1953125; floor(2^45 / 1953125)
    localparam logic [20:0] RCP_D = 21'd1953125;
    localparam logic [24:0] RCP_M = 25'd18014398;

    typedef struct packed {
        logic             start;
        logic [TopW-1:0]  top_speed;
        logic [StepW-1:0] move_length;
    } t_req;
endpackage
`default_nettype wire

/* sv/str_ram.sv */
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module str_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* sv/str_front.sv */
// ---------------------------------------------------------------------------
// Ramp front end
// Accept requests, classify start or advance, queue them for the engine.
// ---------------------------------------------------------------------------
`default_nettype none
module str_front import str_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic                   i_mode,
    input  wire logic [TopW-1:0]        i_top_speed,
    input  wire logic [StepW-1:0]       i_move_length,
    output logic                        o_req_valid,
    input  wire logic                   i_req_ready,
    output t_req                        o_req
);
    t_req r_q [QueueDepth];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;
    t_req req_in;

    always_comb begin
        req_in.start       = !i_mode;
        req_in.top_speed   = i_top_speed;
        req_in.move_length = i_move_length;
    end

    assign o_ready     = (r_cnt != 2'(QueueDepth));
    assign push        = i_valid && o_ready;
    assign o_req_valid = (r_cnt != 2'd0);
    assign pop         = o_req_valid && i_req_ready;
    assign o_req       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= req_in;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

/* sv/str_div.sv */
// ---------------------------------------------------------------------------
// Interval divider
// Compute min(1e9*65536 / speed, max delay), one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module str_div import str_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [SpeedW-1:0] i_speed,
    output logic                   o_done,
    output logic [DelayW-1:0]      o_delay
);
    logic [45:0]       r_num;
    logic [SpeedW:0]   r_rem;
    logic [SpeedW-1:0] r_den;
    logic [45:0]       r_quo;
    logic [5:0]        r_cnt;
    logic              r_busy;
    logic [SpeedW:0]   trial;
    logic              ge;

    assign trial = {r_rem[SpeedW-1:0], r_num[45]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= NS_Q16;
                r_rem  <= '0;
                r_den  <= i_speed;
                r_quo  <= '0;
                r_cnt  <= 6'd46;
            end else if (r_busy) begin
                r_num <= {r_num[44:0], 1'b0};
                r_rem <= ge ? trial - {1'b0, r_den} : trial;
                r_quo <= {r_quo[44:0], ge};
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (r_den == '0 || r_quo[45:DelayW] != '0) begin
            o_delay = DELAY_MAX;
        end else begin
            o_delay = r_quo[DelayW-1:0];
        end
    end
endmodule
`default_nettype wire

/* sv/str_engine.sv */
// ---------------------------------------------------------------------------
// Ramp engine
// Carry out start and advance requests, keep the ramp store, emit steps.
// ---------------------------------------------------------------------------
`default_nettype none
module str_engine import str_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_req_valid,
    output logic                    o_req_ready,
    input  wire t_req               i_req,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [DelayW-1:0]       o_delay_ns,
    output logic [StepW-1:0]        o_step_number,
    output logic [1:0]              o_phase,
    output logic                    o_last_step
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_INC  = 4'd2;
    localparam logic [3:0] S_DIV  = 4'd3;
    localparam logic [3:0] S_RD   = 4'd4;
    localparam logic [3:0] S_OUT  = 4'd5;
    localparam logic [3:0] S_RCP  = 4'd6;
    localparam logic [3:0] S_QE   = 4'd7;
    localparam logic [3:0] S_REM  = 4'd8;
    localparam logic [3:0] S_FIX  = 4'd9;

    logic [3:0]        r_state;
    logic [SpeedW-1:0] r_speed;
    logic [DelayW-1:0] r_cur;
    logic [StepW-1:0]  r_cnt, r_ramp, r_total;
    logic [TopW-1:0]   r_limit;
    logic              r_accel, r_active;
    logic [37:0]       r_prod;
    logic [43:0]       r_ph, r_pl;
    logic [24:0]       r_qe, r_inc;
    logic [45:0]       r_resid;
    logic [StepW-1:0]  r_s;
    logic [DelayW-1:0] r_res_delay;
    logic [1:0]        r_res_phase;
    logic              r_out_valid;
    logic              r_wait_out;
    logic              div_start, div_done;
    logic [DelayW-1:0] div_delay;
    logic              ram_we;
    logic [DelayW-1:0] ram_rdata;
    logic [StepW-1:0]  mirror;
    logic [RampAw-1:0] raddr;
    logic [TopW-1:0]   lim_in;
    logic [62:0]       rcp_sum;
    logic [SpeedW:0]   sp_sum;
    logic [SpeedW:0]   lim_q;
    logic              acc_now;

    assign lim_in   = (i_req.top_speed < TopW'(MinSpeed)) ? TopW'(MinSpeed) : i_req.top_speed;
    assign rcp_sum  = {r_ph, 19'd0} + 63'(r_pl);
    assign sp_sum   = {1'b0, r_speed} + (SpeedW+1)'(r_inc);
    assign lim_q    = (SpeedW+1)'({r_limit, 16'd0});
    assign mirror   = r_total - 16'd1 - r_s;
    assign raddr    = mirror[RampAw-1:0];
    assign acc_now  = r_accel && !(r_cnt >= (r_total >> 1)
                      || {1'b0, r_cnt} >= 17'(RampDepth));

    assign o_req_ready   = (r_state == S_IDLE) && !r_wait_out;
    assign o_valid       = r_out_valid;
    assign o_delay_ns    = r_res_delay;
    assign o_step_number = r_s;
    assign o_phase       = r_res_phase;
    assign o_last_step   = (r_s + 16'd1 == r_total);
    assign div_start     = (r_state == S_INC);
    assign ram_we        = div_done && (r_state == S_DIV);

    str_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_speed (r_speed),
        .o_done  (div_done),
        .o_delay (div_delay)
    );

    str_ram #(.Width(DelayW), .Depth(RampDepth)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s[RampAw-1:0]),
        .i_wdata (div_delay),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_speed     <= SpeedW'(MinSpeed << 16);
            r_cur       <= DELAY_RST;
            r_cnt       <= '0;
            r_ramp      <= '0;
            r_total     <= '0;
            r_limit     <= TopW'(3000);
            r_accel     <= 1'b0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            r_wait_out  <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
                r_wait_out  <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid && o_req_ready) begin
                        if (i_req.start) begin
                            r_limit  <= lim_in;
                            r_total  <= i_req.move_length;
                            r_speed  <= SpeedW'(MinSpeed << 16);
                            r_cur    <= DelayW'(1000000000 / MinSpeed);
                            r_cnt    <= '0;
                            r_ramp   <= '0;
                            r_accel  <= 1'b1;
                            r_active <= (i_req.move_length != '0);
                        end else if (!r_active || r_cnt >= r_total) begin
                            r_active <= 1'b0;
                        end else begin
                            r_s     <= r_cnt;
                            r_accel <= acc_now;
                            r_prod  <= 38'({1'b0, r_limit[TopW-1:1]}) * 38'(r_cur);
                            if (acc_now) begin
                                r_state <= S_RCP;
                            end else if (r_cnt < r_total - r_ramp) begin
                                r_res_delay <= r_cur;
                                r_res_phase <= PH_CRUISE;
                                r_state     <= S_OUT;
                            end else begin
                                r_res_phase <= PH_DECEL;
                                r_state     <= S_RD;
                            end
                        end
                    end
                end
                S_RCP: begin
                    r_ph    <= r_prod[37:19] * RCP_M;
                    r_pl    <= r_prod[18:0] * RCP_M;
                    r_state <= S_QE;
                end
                S_QE: begin
                    r_qe    <= rcp_sum[62:38];
                    r_state <= S_REM;
                end
                S_REM: begin
                    r_resid <= 46'({r_prod, 7'd0}) - 46'(r_qe) * 46'(RCP_D);
                    r_state <= S_FIX;
                end
                S_FIX: begin
                    r_inc   <= r_qe + 25'(r_resid >= 46'(RCP_D));
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (sp_sum > lim_q) begin
                        r_speed <= lim_q[SpeedW-1:0];
                        r_accel <= 1'b0;
                    end else begin
                        r_speed <= sp_sum[SpeedW-1:0];
                    end
                    r_state <= S_INC;
                end
                S_INC: r_state <= S_DIV;
                S_DIV: begin
                    if (div_done) begin
                        r_cur       <= div_delay;
                        r_res_delay <= div_delay;
                        r_res_phase <= PH_ACCEL;
                        r_ramp      <= r_s + 16'd1;
                        r_state     <= S_OUT;
                    end
                end
                S_RD: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (r_res_phase == PH_DECEL) begin
                        if (mirror < r_ramp && {1'b0, mirror} < 17'(RampDepth)) begin
                            r_res_delay <= ram_rdata;
                        end else begin
                            r_res_delay <= r_cur;
                        end
                    end
                    r_cnt       <= r_s + 16'd1;
                    if (r_s + 16'd1 >= r_total) r_active <= 1'b0;
                    r_out_valid <= 1'b1;
                    r_wait_out  <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* sv/stepper_trapezoid_ramp_core.sv */
// ---------------------------------------------------------------------------
// Stepper trapezoid ramp core
// Each advance request during an active move yields one step interval in ns with its phase.
// ---------------------------------------------------------------------------
// From acceptance to result a cruise step passes S_OUT, a deceleration
// step S_RD (registered ramp store read) and S_OUT, an acceleration step
// S_RCP, S_QE, S_REM and S_FIX (reciprocal multiplication forms
// accel*delay/1e9 in Q16), S_MUL, S_INC, S_DIV (a bit-serial divider forms
// 1e9*65536/speed one quotient bit per cycle) and S_OUT. A start request is
// handled in the idle state. A two-entry request queue parts the input from
// the engine, which takes no new request while a result waits.
`default_nettype none
`include "stepper_trapezoid_ramp_core_macros.svh"
module stepper_trapezoid_ramp_core import str_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_mode,
    input  wire logic [TopW-1:0]    i_top_speed,
    input  wire logic [StepW-1:0]   i_move_length,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [DelayW-1:0]       o_delay_ns,
    output logic [StepW-1:0]        o_step_number,
    output logic [1:0]              o_phase,
    output logic                    o_last_step
);
    logic req_valid, req_ready;
    t_req req;

    str_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_top_speed   (i_top_speed),
        .i_move_length (i_move_length),
        .o_req_valid   (req_valid),
        .i_req_ready   (req_ready),
        .o_req         (req)
    );

    str_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (req_valid),
        .o_req_ready   (req_ready),
        .i_req         (req),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_delay_ns    (o_delay_ns),
        .o_step_number (o_step_number),
        .o_phase       (o_phase),
        .o_last_step   (o_last_step)
    );

    `STR_ASSERT_IMPL(a_phase_code, i_clk, i_rst_n, o_valid, o_phase != 2'd3, "bad phase code")
    `STR_ASSERT_NEXT(a_hold_out, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_delay_ns) && $stable(o_step_number), "result changed while stalled")
    `STR_ASSERT_IMPL(a_no_take_busy, i_clk, i_rst_n, req_ready, !o_valid,
        "engine ready while a result waits")
endmodule
`default_nettype wire
